// ===== sv/slot_pool_manager_core_defines.svh =====
// assertion macros for the slot pool manager checker
`ifndef SLOT_POOL_MANAGER_CORE_DEFINES_SVH
`define SLOT_POOL_MANAGER_CORE_DEFINES_SVH

// same-cycle implication, reset masked
`define SPM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slot pool check failed");

// next-cycle implication, reset masked
`define SPM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slot pool check failed");

`endif

// ===== sv/spm_pkg.sv =====
// shared types and codes for the slot pool manager
`timescale 1ns / 1ps

package spm_pkg;

   // request kinds
   localparam logic [2:0] KIND_ACQ_ANY   = 3'd0;
   localparam logic [2:0] KIND_ACQ_SLOT  = 3'd1;
   localparam logic [2:0] KIND_RELEASE   = 3'd2;
   localparam logic [2:0] KIND_HEALTH    = 3'd3;
   localparam logic [2:0] KIND_RECONNECT = 3'd4;
   localparam logic [2:0] KIND_RETRY_DUE = 3'd5;
   localparam logic [2:0] KIND_SCAN      = 3'd6;

   // response status codes
   localparam logic [2:0] STAT_GRANTED   = 3'd0;
   localparam logic [2:0] STAT_NONE_FREE = 3'd1;
   localparam logic [2:0] STAT_NOT_READY = 3'd2;
   localparam logic [2:0] STAT_INVALID   = 3'd3;
   localparam logic [2:0] STAT_RETRY     = 3'd4;
   localparam logic [2:0] STAT_RECONNECT = 3'd5;
   localparam logic [2:0] STAT_DONE      = 3'd6;

   // register indexes
   localparam logic [2:0] CSR_BASE      = 3'd0;
   localparam logic [2:0] CSR_MAX       = 3'd1;
   localparam logic [2:0] CSR_MAX_SHIFT = 3'd2;
   localparam logic [2:0] CSR_JITTER    = 3'd3;

   localparam logic [4:0]  MAX_RESULTS_M1 = 5'd15;
   localparam logic [15:0] LFSR_SEED      = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS      = 16'hB400;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_GRANT_ONE,
      OP_INC,
      OP_DEC,
      OP_SET_HEALTH,
      OP_RECON_OK,
      OP_RECON_FAIL,
      OP_SET_RETRY,
      OP_CLR_RETRY
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        flag;
   } cell_cmd_type;

   typedef struct packed {
      logic       use_zero;
      logic       healthy;
      logic [4:0] fail_cnt;
      logic       retry;
   } cell_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_SCAN,
      ST_SCAN_END,
      ST_BACK1,
      ST_BACK2
   } ctl_state_type;

endpackage

// ===== sv/spm_cell.sv =====
// one slot cell: use count, health, failure count and retry flag
`timescale 1ns / 1ps

module spm_cell import spm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   output cell_stat_type stat
);

   logic [7:0] use_ff, use_in;
   logic       healthy_ff, healthy_in;
   logic [4:0] fail_ff, fail_in;
   logic       retry_ff, retry_in;

   // apply the broadcast command
   always_comb begin
      use_in     = use_ff;
      healthy_in = healthy_ff;
      fail_in    = fail_ff;
      retry_in   = retry_ff;
      case (cmd.op)
         OP_GRANT_ONE: use_in = 8'd1;
         OP_INC: if (use_ff != 8'hFF) use_in = use_ff + 8'd1;
         OP_DEC: if (use_ff != 8'h00) use_in = use_ff - 8'd1;
         OP_SET_HEALTH: healthy_in = cmd.flag;
         OP_RECON_OK: begin
            if (use_ff == 8'h00) healthy_in = 1'b1;
            fail_in  = 5'd0;
            retry_in = 1'b0;
         end
         OP_RECON_FAIL: begin
            if (fail_ff != 5'd31) fail_in = fail_ff + 5'd1;
            retry_in = 1'b1;
         end
         OP_SET_RETRY: retry_in = 1'b1;
         OP_CLR_RETRY: retry_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff     <= 8'd0;
         healthy_ff <= 1'b0;
         fail_ff    <= 5'd0;
         retry_ff   <= 1'b0;
      end else begin
         use_ff     <= use_in;
         healthy_ff <= healthy_in;
         fail_ff    <= fail_in;
         retry_ff   <= retry_in;
      end
   end

   assign stat.use_zero = (use_ff == 8'd0);
   assign stat.healthy  = healthy_ff;
   assign stat.fail_cnt = fail_ff;
   assign stat.retry    = retry_ff;

endmodule

// ===== sv/slot_pool_manager_core.sv =====
// slot pool manager top level: sequencer over a row of slot cells
// from accept to result register: single-slot kinds pass through exec, a reconnect failure
// through exec, back1 and back2, acquire_any through exec and a search of the slots, and a
// health scan through exec, scan and scan_end; results wait on a full output register
// throughput one transaction at a time; the output register lets req accept while rsp waits
// synchronous reset clears all cells, the hint, and seeds the lfsr to 0xACE1
`timescale 1ns / 1ps

module slot_pool_manager_core import spm_pkg::*; #(
   parameter int POOL_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_slot,
   input  logic        req_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_slot_out,
   output logic [22:0] rsp_delay_ms,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_wdata
);

   localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam logic [SW-1:0] LAST_IDX = SW'(POOL_SLOTS - 1);

   // configuration registers
   logic [15:0] base_ff;
   logic [21:0] max_ff;
   logic [4:0]  shift_max_ff;
   logic [15:0] jit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= 16'd500;
         max_ff       <= 22'd30000;
         shift_max_ff <= 5'd6;
         jit_ff       <= 16'd250;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE:      base_ff      <= csr_wdata[15:0];
            CSR_MAX:       max_ff       <= csr_wdata;
            CSR_MAX_SHIFT: shift_max_ff <= csr_wdata[4:0];
            CSR_JITTER:    jit_ff       <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // row of slot cells
   cell_cmd_type  cmd_bus;
   logic [SW-1:0] cmd_sel;
   cell_stat_type cell_st [POOL_SLOTS];

   for (genvar g = 0; g < POOL_SLOTS; g++) begin : g_cell
      cell_cmd_type cmd_g;
      assign cmd_g.op   = (cmd_sel == SW'(g)) ? cmd_bus.op : OP_NONE;
      assign cmd_g.flag = cmd_bus.flag;
      spm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd_g),
         .stat  (cell_st[g])
      );
   end

   // sequencer registers
   ctl_state_type state_ff, state_in;
   logic [2:0]    kind_ff, kind_in;
   logic [7:0]    slot_ff, slot_in;
   logic          flag_ff, flag_in;
   logic [SW-1:0] hint_ff, hint_in;
   logic [SW-1:0] ptr_ff, ptr_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [4:0]    found_ff, found_in;
   logic          pend_ff, pend_in;
   logic [SW-1:0] pslot_ff, pslot_in;
   logic [15:0]   lfsr_ff, lfsr_in;
   logic [4:0]    shift_ff, shift_in;
   logic [21:0]   clamp_ff, clamp_in;
   logic [32:0]   prod_ff, prod_in;

   // output register
   logic          ov_ff, ov_in;
   logic [2:0]    ost_ff, ost_in;
   logic [5:0]    oslot_ff, oslot_in;
   logic [22:0]   odly_ff, odly_in;
   logic          olast_ff, olast_in;

   logic          out_free;
   logic [SW-1:0] sidx;
   cell_stat_type sel_st, ptr_st;
   logic          slot_bad;
   logic          ptr_q;
   logic          acq_ok;
   logic [4:0]    fail_nx;
   logic [46:0]   shifted;

   assign out_free = !ov_ff || rsp_ready;
   assign sidx     = slot_ff[SW-1:0];
   assign sel_st   = cell_st[sidx];
   assign ptr_st   = cell_st[ptr_ff];
   assign slot_bad = (slot_ff >= 8'(POOL_SLOTS));
   assign acq_ok   = ptr_st.use_zero && ptr_st.healthy;
   assign ptr_q    = ptr_st.use_zero && !ptr_st.healthy && !ptr_st.retry &&
                     (ptr_st.fail_cnt == 5'd0);
   assign fail_nx  = (sel_st.fail_cnt == 5'd31) ? 5'd31 : sel_st.fail_cnt + 5'd1;
   assign shifted  = {31'd0, base_ff} << shift_ff;
   assign req_ready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (kind_ff == KIND_ACQ_ANY) state_in = ST_SEARCH;
            else if (kind_ff == KIND_SCAN) state_in = ST_SCAN;
            else if (kind_ff > KIND_SCAN) state_in = ST_IDLE;
            else if (!slot_bad && kind_ff == KIND_RECONNECT && !flag_ff)
               state_in = ST_BACK1;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_SEARCH: if (out_free && (acq_ok || cnt_ff == LAST_IDX)) state_in = ST_IDLE;
         ST_SCAN: begin
            if (!(ptr_q && pend_ff && !out_free) &&
                ((ptr_q && found_ff == MAX_RESULTS_M1) || ptr_ff == LAST_IDX))
               state_in = ST_SCAN_END;
         end
         ST_SCAN_END: if (out_free) state_in = ST_IDLE;
         ST_BACK1: state_in = ST_BACK2;
         ST_BACK2: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and cell commands
   always_comb begin
      kind_in  = kind_ff;
      slot_in  = slot_ff;
      flag_in  = flag_ff;
      hint_in  = hint_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      found_in = found_ff;
      pend_in  = pend_ff;
      pslot_in = pslot_ff;
      lfsr_in  = lfsr_ff;
      shift_in = shift_ff;
      clamp_in = clamp_ff;
      prod_in  = prod_ff;
      ov_in    = ov_ff && !rsp_ready;
      ost_in   = ost_ff;
      oslot_in = oslot_ff;
      odly_in  = odly_ff;
      olast_in = olast_ff;
      cmd_bus.op   = OP_NONE;
      cmd_bus.flag = flag_ff;
      cmd_sel  = sidx;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               slot_in = req_slot;
               flag_in = req_flag;
            end
         end
         ST_EXEC: begin
            if (kind_ff == KIND_ACQ_ANY) begin
               ptr_in  = hint_ff;
               cnt_in  = '0;
               hint_in = (hint_ff == LAST_IDX) ? '0 : hint_ff + SW'(1);
            end else if (kind_ff == KIND_SCAN) begin
               ptr_in   = '0;
               found_in = 5'd0;
               pend_in  = 1'b0;
            end else if (kind_ff > KIND_SCAN) begin
               ov_in = ov_ff && !rsp_ready;
            end else if (slot_bad) begin
               if (out_free) begin
                  ov_in = 1'b1; ost_in = STAT_INVALID; oslot_in = 6'd0;
                  odly_in = 23'd0; olast_in = 1'b1;
               end
            end else if (kind_ff == KIND_RECONNECT && !flag_ff) begin
               cmd_bus.op = OP_RECON_FAIL;
               shift_in = (fail_nx > shift_max_ff) ? shift_max_ff : fail_nx;
               lfsr_in  = lfsr_ff[0] ? ({1'b0, lfsr_ff[15:1]} ^ LFSR_TAPS)
                                     : {1'b0, lfsr_ff[15:1]};
            end else if (out_free) begin
               ov_in = 1'b1; oslot_in = 6'(sidx); odly_in = 23'd0; olast_in = 1'b1;
               ost_in = STAT_DONE;
               case (kind_ff)
                  KIND_ACQ_SLOT: begin
                     if (sel_st.healthy) begin
                        ost_in = STAT_GRANTED; cmd_bus.op = OP_INC;
                     end else begin
                        ost_in = STAT_NOT_READY;
                     end
                  end
                  KIND_RELEASE: cmd_bus.op = OP_DEC;
                  KIND_HEALTH:  cmd_bus.op = OP_SET_HEALTH;
                  KIND_RECONNECT: cmd_bus.op = OP_RECON_OK;
                  default: begin
                     if (sel_st.use_zero && !sel_st.healthy) begin
                        ost_in = STAT_RECONNECT; cmd_bus.op = OP_SET_RETRY;
                     end else begin
                        cmd_bus.op = OP_CLR_RETRY;
                     end
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            cmd_sel = ptr_ff;
            if (out_free) begin
               if (acq_ok) begin
                  cmd_bus.op = OP_GRANT_ONE;
                  ov_in = 1'b1; ost_in = STAT_GRANTED; oslot_in = 6'(ptr_ff);
                  odly_in = 23'd0; olast_in = 1'b1;
               end else if (cnt_ff == LAST_IDX) begin
                  ov_in = 1'b1; ost_in = STAT_NONE_FREE; oslot_in = 6'd0;
                  odly_in = 23'd0; olast_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + SW'(1);
                  ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + SW'(1);
               end
            end
         end
         ST_SCAN: begin
            cmd_sel = ptr_ff;
            if (!(ptr_q && pend_ff && !out_free)) begin
               if (ptr_q) begin
                  cmd_bus.op = OP_SET_RETRY;
                  if (pend_ff) begin
                     ov_in = 1'b1; ost_in = STAT_RECONNECT; oslot_in = 6'(pslot_ff);
                     odly_in = 23'd0; olast_in = 1'b0;
                  end
                  pend_in  = 1'b1;
                  pslot_in = ptr_ff;
                  found_in = found_ff + 5'd1;
               end
               ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + SW'(1);
            end
         end
         ST_SCAN_END: begin
            if (out_free) begin
               ov_in = 1'b1; odly_in = 23'd0; olast_in = 1'b1;
               ost_in   = pend_ff ? STAT_RECONNECT : STAT_DONE;
               oslot_in = pend_ff ? 6'(pslot_ff) : 6'd0;
            end
         end
         ST_BACK1: begin
            clamp_in = (shifted > {25'd0, max_ff}) ? max_ff : shifted[21:0];
            prod_in  = {17'd0, lfsr_ff} * ({17'd0, jit_ff} + 33'd1);
         end
         ST_BACK2: begin
            if (out_free) begin
               ov_in = 1'b1; ost_in = STAT_RETRY; oslot_in = 6'(sidx);
               odly_in  = {1'b0, clamp_ff} + {6'd0, prod_ff[32:16]};
               olast_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hint_ff  <= '0;
         lfsr_ff  <= LFSR_SEED;
         ov_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hint_ff  <= hint_in;
         lfsr_ff  <= lfsr_in;
         ov_ff    <= ov_in;
         pend_ff  <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      slot_ff  <= slot_in;
      flag_ff  <= flag_in;
      ptr_ff   <= ptr_in;
      cnt_ff   <= cnt_in;
      found_ff <= found_in;
      pslot_ff <= pslot_in;
      shift_ff <= shift_in;
      clamp_ff <= clamp_in;
      prod_ff  <= prod_in;
      ost_ff   <= ost_in;
      oslot_ff <= oslot_in;
      odly_ff  <= odly_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid    = ov_ff;
   assign rsp_status   = ost_ff;
   assign rsp_slot_out = oslot_ff;
   assign rsp_delay_ms = odly_ff;
   assign rsp_last     = olast_ff;

endmodule

// ===== sv/spm_checker.sv =====
// port-level checks for the slot pool manager, bound to the top level
`timescale 1ns / 1ps
`include "slot_pool_manager_core_defines.svh"

module spm_checker import spm_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [5:0]  rsp_slot_out,
   input logic [22:0] rsp_delay_ms,
   input logic        rsp_last
);

   // a stalled response transaction stays offered
   `SPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   // none free never names a slot
   `SPM_ASSERT_NOW(a_none_slot, rsp_valid && rsp_status == STAT_NONE_FREE, rsp_slot_out == 6'd0)
   // a retry is always the only result of its transaction
   `SPM_ASSERT_NOW(a_retry_last, rsp_valid && rsp_status == STAT_RETRY, rsp_last)
   // delay only travels with a retry
   `SPM_ASSERT_NOW(a_delay_zero, rsp_valid && rsp_status != STAT_RETRY, rsp_delay_ms == 23'd0)

endmodule

bind slot_pool_manager_core spm_checker u_spm_checker (.*);

// ===== bench/slot_pool_manager_core_tb.sv =====
// testbench for the slot pool manager: directed and random transactions against a predictor
`timescale 1ns / 1ps

module slot_pool_manager_core_tb;
   import spm_pkg::*;

   localparam int NSLOTS = 16;
   localparam int SCAN_MAX = 16;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot_out;
      logic [22:0] delay_ms;
      logic        last;
   } pool_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [7:0]  req_slot = '0;
   logic        req_flag = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_slot_out;
   logic [22:0] rsp_delay_ms;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [21:0] csr_wdata = '0;

   // predictor state
   logic [7:0]  pm_use [NSLOTS];
   logic        pm_healthy [NSLOTS];
   logic [4:0]  pm_fails [NSLOTS];
   logic        pm_retry [NSLOTS];
   logic [3:0]  pm_hint;
   logic [15:0] pm_lfsr;
   logic [15:0] pm_base;
   logic [21:0] pm_max;
   logic [4:0]  pm_shift;
   logic [15:0] pm_jitter;

   pool_rsp_type expected_rsps [$];
   int           error_count = 0;
   longint       cycle_count = 0;

   slot_pool_manager_core #(.POOL_SLOTS(NSLOTS)) dut (.*);

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic pool_rsp_type mk_rsp(logic [2:0] st, int sl, longint d, bit lst);
      pool_rsp_type r;
      r.status = st; r.slot_out = 6'(sl); r.delay_ms = 23'(d); r.last = lst;
      return r;
   endfunction

   // append one expected response transaction
   task automatic add_expected(input pool_rsp_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   // model of one transaction; queues its responses
   task automatic predict_pool(input logic [2:0] kind, input logic [7:0] s, input logic flag);
      int start, idx, found, k, shamt;
      logic [63:0] dly, jit;
      logic [3:0] si;
      if (kind == KIND_ACQ_ANY) begin
         start = int'(pm_hint);
         pm_hint = pm_hint + 4'd1;
         found = -1;
         for (int j = 0; j < NSLOTS; j++) begin
            idx = (start + j) % NSLOTS;
            if (found < 0 && pm_use[idx] == 8'd0 && pm_healthy[idx]) found = idx;
         end
         if (found >= 0) begin
            pm_use[found] = 8'd1;
            add_expected(mk_rsp(STAT_GRANTED, found, 0, 1'b1));
         end else add_expected(mk_rsp(STAT_NONE_FREE, 0, 0, 1'b1));
         return;
      end
      if (kind == KIND_SCAN) begin
         k = 0;
         for (int i = 0; i < NSLOTS; i++)
            if (k < SCAN_MAX && pm_use[i] == 8'd0 && !pm_healthy[i] && !pm_retry[i]
                && pm_fails[i] == 5'd0) begin
               pm_retry[i] = 1'b1;
               add_expected(mk_rsp(STAT_RECONNECT, i, 0, 1'b0));
               k++;
            end
         if (k == 0) add_expected(mk_rsp(STAT_DONE, 0, 0, 1'b1));
         else expected_rsps[$].last = 1'b1;
         return;
      end
      if (kind == 3'd7) return;
      if (s >= 8'(NSLOTS)) begin
         add_expected(mk_rsp(STAT_INVALID, 0, 0, 1'b1));
         return;
      end
      si = s[3:0];
      case (kind)
         KIND_ACQ_SLOT: begin
            if (!pm_healthy[si]) add_expected(mk_rsp(STAT_NOT_READY, int'(si), 0, 1'b1));
            else begin
               if (pm_use[si] != 8'hFF) pm_use[si]++;
               add_expected(mk_rsp(STAT_GRANTED, int'(si), 0, 1'b1));
            end
         end
         KIND_RELEASE: begin
            if (pm_use[si] != 8'd0) pm_use[si]--;
            add_expected(mk_rsp(STAT_DONE, int'(si), 0, 1'b1));
         end
         KIND_HEALTH: begin
            pm_healthy[si] = flag;
            add_expected(mk_rsp(STAT_DONE, int'(si), 0, 1'b1));
         end
         KIND_RECONNECT: begin
            if (flag) begin
               if (pm_use[si] == 8'd0) pm_healthy[si] = 1'b1;
               pm_fails[si] = 5'd0;
               pm_retry[si] = 1'b0;
               add_expected(mk_rsp(STAT_DONE, int'(si), 0, 1'b1));
            end else begin
               if (pm_fails[si] != 5'd31) pm_fails[si]++;
               shamt = int'((pm_fails[si] > pm_shift) ? pm_shift : pm_fails[si]);
               dly = 64'(pm_base) << shamt;
               if (dly > 64'(pm_max)) dly = 64'(pm_max);
               pm_lfsr = pm_lfsr[0] ? ((pm_lfsr >> 1) ^ LFSR_TAPS) : (pm_lfsr >> 1);
               jit = (64'(pm_lfsr) * (64'(pm_jitter) + 64'd1)) >> 16;
               dly = dly + jit;
               pm_retry[si] = 1'b1;
               add_expected(mk_rsp(STAT_RETRY, int'(si), longint'(dly), 1'b1));
            end
         end
         default: begin
            if (pm_use[si] == 8'd0 && !pm_healthy[si]) begin
               pm_retry[si] = 1'b1;
               add_expected(mk_rsp(STAT_RECONNECT, int'(si), 0, 1'b1));
            end else begin
               pm_retry[si] = 1'b0;
               add_expected(mk_rsp(STAT_DONE, int'(si), 0, 1'b1));
            end
         end
      endcase
   endtask

   // response checker with random back-pressure
   initial begin
      int wait_cycles;
      pool_rsp_type want;
      @(negedge reset);
      forever begin
         wait_cycles = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) wait_cycles = 0;
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_rsps.size() == 0) begin
            $display("unexpected response status %0d at cycle %0d", rsp_status, cycle_count);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_slot_out !== want.slot_out)
               report_mismatch("slot_out", 32'(rsp_slot_out), 32'(want.slot_out));
            if (rsp_delay_ms !== want.delay_ms)
               report_mismatch("delay_ms", 32'(rsp_delay_ms), 32'(want.delay_ms));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // one request transaction with a random gap before it; valid stays up for a zero gap
   task automatic send_req(input logic [2:0] kind, input logic [7:0] s, input logic flag);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_slot  <= s;
      req_flag  <= flag;
      do @(posedge clock); while (!req_ready);
      predict_pool(kind, s, flag);
   endtask

   task automatic drain_pool();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [21:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BASE:      pm_base   = val[15:0];
         CSR_MAX:       pm_max    = val;
         CSR_MAX_SHIFT: pm_shift  = val[4:0];
         CSR_JITTER:    pm_jitter = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_backoff(input logic [21:0] b, input logic [21:0] m,
                              input logic [21:0] sh, input logic [21:0] j);
      drain_pool();
      write_csr(CSR_BASE, b);
      write_csr(CSR_MAX, m);
      write_csr(CSR_MAX_SHIFT, sh);
      write_csr(CSR_JITTER, j);
      csr_valid <= 1'b0;
   endtask

   // directed: every kind, invalid slots, saturation, empty scan
   task automatic test_directed();
      send_req(KIND_ACQ_ANY, 8'd0, 1'b0);
      send_req(KIND_ACQ_SLOT, 8'd3, 1'b0);
      send_req(KIND_SCAN, 8'd0, 1'b0);
      send_req(KIND_SCAN, 8'd0, 1'b0);
      send_req(KIND_RETRY_DUE, 8'd2, 1'b0);
      send_req(KIND_HEALTH, 8'd5, 1'b1);
      send_req(KIND_ACQ_ANY, 8'hFF, 1'b1);
      send_req(KIND_ACQ_SLOT, 8'd5, 1'b0);
      send_req(KIND_RELEASE, 8'd5, 1'b0);
      send_req(KIND_RELEASE, 8'd5, 1'b0);
      send_req(KIND_RECONNECT, 8'd7, 1'b0);
      send_req(KIND_RECONNECT, 8'd7, 1'b0);
      send_req(KIND_RETRY_DUE, 8'd7, 1'b0);
      send_req(KIND_RECONNECT, 8'd7, 1'b1);
      send_req(KIND_RETRY_DUE, 8'd5, 1'b0);
      send_req(KIND_ACQ_SLOT, 8'hFF, 1'b1);
      send_req(KIND_RELEASE, 8'd16, 1'b0);
      send_req(KIND_HEALTH, 8'hAA, 1'b1);
      send_req(3'd7, 8'h55, 1'b1);
      send_req(KIND_ACQ_SLOT, 8'd5, 1'b1);
      send_req(KIND_RECONNECT, 8'd5, 1'b1);
      send_req(KIND_HEALTH, 8'd15, 1'b1);
      send_req(KIND_ACQ_ANY, 8'd0, 1'b0);
   endtask

   // use count saturation on one slot
   task automatic test_saturation();
      send_req(KIND_HEALTH, 8'd9, 1'b1);
      repeat (256) send_req(KIND_ACQ_SLOT, 8'd9, 1'($urandom_range(0, 1)));
      repeat (2) send_req(KIND_RELEASE, 8'd9, 1'b0);
   endtask

   // failure count saturation under extreme backoff settings
   task automatic test_backoff_extremes();
      set_backoff(22'hFFFF, 22'h3FFFFF, 22'd30, 22'hFFFF);
      repeat (34) send_req(KIND_RECONNECT, 8'd11, 1'b0);
      set_backoff(22'd1, 22'd1, 22'd0, 22'd0);
      repeat (6) send_req(KIND_RECONNECT, 8'd12, 1'b0);
      set_backoff(22'h3FFFFF, 22'h3FFFFF, 22'h1F, 22'h3FFFFF);
      repeat (6) send_req(KIND_RECONNECT, 8'd13, 1'b0);
   endtask

   // random mix, mostly valid slots
   task automatic test_random(input int n);
      logic [2:0] k;
      logic [7:0] s;
      for (int i = 0; i < n; i++) begin
         k = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 9) == 0) s = 8'($urandom_range(0, 255));
         else s = 8'($urandom_range(0, NSLOTS - 1));
         send_req(k, s, 1'($urandom_range(0, 1)));
         if (i % 125 == 124)
            set_backoff(22'($urandom_range(1, 65535)), 22'($urandom_range(1, 4194303)),
                        22'($urandom_range(0, 30)), 22'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOTS; i++) begin
         pm_use[i] = '0; pm_healthy[i] = 1'b0; pm_fails[i] = '0; pm_retry[i] = 1'b0;
      end
      pm_hint = '0; pm_lfsr = LFSR_SEED;
      pm_base = 16'd500; pm_max = 22'd30000; pm_shift = 5'd6; pm_jitter = 16'd250;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (NSLOTS + 4) @(posedge clock);
      test_directed();
      test_saturation();
      test_backoff_extremes();
      set_backoff(22'd500, 22'd30000, 22'd6, 22'd250);
      test_random(170);
      drain_pool();
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
